// ===== rtl/core/sha256_message_hasher_core_assert.svh =====
// assertion macros for the sha256 message hasher
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define SHA_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/shamh_pkg.sv =====
// package: states, constants and round function helpers for the sha256 hasher
`default_nettype none
package shamh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    case (t)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shamh_round.sv =====
// one sha256 round plus message schedule step, used once per cycle
`default_nettype none
module shamh_round (
  input  wire  logic [31:0] va,
  input  wire  logic [31:0] vb,
  input  wire  logic [31:0] vc,
  input  wire  logic [31:0] vd,
  input  wire  logic [31:0] ve,
  input  wire  logic [31:0] vf,
  input  wire  logic [31:0] vg,
  input  wire  logic [31:0] vh,
  input  wire  logic [31:0] kt,
  input  wire  logic [31:0] wt,
  input  wire  logic [31:0] w1,
  input  wire  logic [31:0] w9,
  input  wire  logic [31:0] w14,
  output logic [31:0] new_a,
  output logic [31:0] new_e,
  output logic [31:0] w_new
);
  logic [31:0] s1, chf, t1, s0, mj, sg0, sg1;

  always_comb begin
    s1  = shamh_pkg::rotr(ve, 6) ^ shamh_pkg::rotr(ve, 11) ^ shamh_pkg::rotr(ve, 25);
    chf = (ve & vf) ^ (~ve & vg);
    t1  = vh + s1 + chf + kt + wt;
    s0  = shamh_pkg::rotr(va, 2) ^ shamh_pkg::rotr(va, 13) ^ shamh_pkg::rotr(va, 22);
    mj  = (va & vb) ^ (va & vc) ^ (vb & vc);
    new_a = t1 + s0 + mj;
    new_e = vd + t1;
    // schedule: window holds w[t..t+15], next is w[t+16]
    sg0 = shamh_pkg::rotr(w1, 7) ^ shamh_pkg::rotr(w1, 18) ^ (w1 >> 3);
    sg1 = shamh_pkg::rotr(w14, 17) ^ shamh_pkg::rotr(w14, 19) ^ (w14 >> 10);
    w_new = wt + sg0 + w9 + sg1;
  end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_message_hasher_core.sv =====
// top level: byte-serial sha256 hasher with one shared round unit
// input bytes are accepted only in the idle state; the 64th byte of a block starts
// the round phase: the shared round unit runs the rounds, then folds into the chaining value
// end of message: padding bytes fill the block, whose rounds then run; a second block
// of zero padding with the length follows when needed, then 8 digest words, one per output beat
// no byte is taken while rounds, padding or output run; synchronous active-low reset loads
// the initial hash values, clears the byte count and the control state
`default_nettype none
module sha256_message_hasher_core (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_tvalid,
  output logic              in_tready,
  input  wire  logic [7:0]  in_tdata,   // data_byte
  input  wire  logic        in_tuser,   // byte_valid
  input  wire  logic        in_tlast,   // end_of_message
  output logic              out_tvalid,
  input  wire  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast   // last_word
);
  shamh_pkg::state_t state_r, state_nxt;

  logic [31:0] blk_r [16];     // block buffer, also the schedule window
  logic [31:0] h_r   [8];      // chaining value
  logic [31:0] v_r   [8];      // working variables
  logic [63:0] total_r;
  logic [5:0]  rnd_r;          // round counter
  logic        fold_r;         // add working vars into chain next cycle
  logic        eom_r;          // padding owed after the current block
  logic        two_r;          // marker block had no room for the length
  logic        fin_r;          // the block running is the last one
  logic [5:0]  pad_r;          // padding byte position
  logic [2:0]  oidx_r;

  logic [31:0] new_a, new_e, w_new;
  logic        acc, byte_in, blk_full;
  logic [5:0]  pos;

  assign acc      = in_tvalid & in_tready;
  assign pos      = total_r[5:0];
  assign byte_in  = acc & in_tuser;
  assign blk_full = byte_in & (pos == 6'd63);

  shamh_round u_round (
    .va(v_r[0]), .vb(v_r[1]), .vc(v_r[2]), .vd(v_r[3]),
    .ve(v_r[4]), .vf(v_r[5]), .vg(v_r[6]), .vh(v_r[7]),
    .kt(shamh_pkg::round_k(rnd_r)), .wt(blk_r[0]), .w1(blk_r[1]),
    .w9(blk_r[9]), .w14(blk_r[14]),
    .new_a(new_a), .new_e(new_e), .w_new(w_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shamh_pkg::ST_IDLE: begin
        if (blk_full) state_nxt = shamh_pkg::ST_ROUND;
        else if (acc && in_tlast) state_nxt = shamh_pkg::ST_PAD;
      end
      shamh_pkg::ST_ROUND: begin
        if (fold_r) begin
          if (fin_r) state_nxt = shamh_pkg::ST_OUT;
          else if (eom_r || two_r) state_nxt = shamh_pkg::ST_PAD;
          else state_nxt = shamh_pkg::ST_IDLE;
        end
      end
      shamh_pkg::ST_PAD: begin
        if (pad_r == 6'd63) state_nxt = shamh_pkg::ST_ROUND;
      end
      shamh_pkg::ST_OUT: begin
        if (out_tready && oidx_r == 3'd7) state_nxt = shamh_pkg::ST_IDLE;
      end
      default: state_nxt = shamh_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == shamh_pkg::ST_IDLE);
    out_tvalid = (state_r == shamh_pkg::ST_OUT);
    out_tdata  = {5'd0, oidx_r, h_r[oidx_r]};
    out_tlast  = (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shamh_pkg::ST_IDLE;
      total_r <= '0;
      rnd_r   <= '0;
      fold_r  <= 1'b0;
      eom_r   <= 1'b0;
      two_r   <= 1'b0;
      fin_r   <= 1'b0;
      pad_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= shamh_pkg::init_hash(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        shamh_pkg::ST_IDLE: begin
          if (byte_in) begin
            case (pos[1:0])
              2'd0: blk_r[pos[5:2]][31:24] <= in_tdata;
              2'd1: blk_r[pos[5:2]][23:16] <= in_tdata;
              2'd2: blk_r[pos[5:2]][15:8]  <= in_tdata;
              default: blk_r[pos[5:2]][7:0] <= in_tdata;
            endcase
            total_r <= total_r + 64'd1;
          end
          if (acc) begin
            eom_r  <= in_tlast;
            two_r  <= 1'b0;
            fin_r  <= 1'b0;
            // pad phase starts with the marker at the current position
            pad_r  <= byte_in ? pos + 6'd1 : pos;
            rnd_r  <= '0;
            fold_r <= 1'b0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        shamh_pkg::ST_ROUND: begin
          if (!fold_r) begin
            v_r[0] <= new_a; v_r[1] <= v_r[0]; v_r[2] <= v_r[1]; v_r[3] <= v_r[2];
            v_r[4] <= new_e; v_r[5] <= v_r[4]; v_r[6] <= v_r[5]; v_r[7] <= v_r[6];
            for (int i = 0; i < 15; i++) blk_r[i] <= blk_r[i + 1];
            blk_r[15] <= w_new;
            rnd_r <= rnd_r + 6'd1;
            if (rnd_r == 6'd63) fold_r <= 1'b1;
          end else begin
            fold_r <= 1'b0;
            for (int i = 0; i < 8; i++) begin
              h_r[i] <= h_r[i] + v_r[i];
              v_r[i] <= h_r[i] + v_r[i];
            end
          end
        end
        shamh_pkg::ST_PAD: begin
          if (pad_r == 6'd63 && (two_r || total_r[5:0] <= 6'd55)) begin
            // last block: bit length fills the final two words
            fin_r <= 1'b1;
            blk_r[14] <= total_r[60:29];
            blk_r[15] <= {total_r[28:0], 3'd0};
          end else begin
            // marker byte at the first pad position when owed, zeros after it
            case (pad_r[1:0])
              2'd0: blk_r[pad_r[5:2]][31:24] <= eom_r ? shamh_pkg::PAD_MARK : 8'd0;
              2'd1: blk_r[pad_r[5:2]][23:16] <= eom_r ? shamh_pkg::PAD_MARK : 8'd0;
              2'd2: blk_r[pad_r[5:2]][15:8]  <= eom_r ? shamh_pkg::PAD_MARK : 8'd0;
              default: blk_r[pad_r[5:2]][7:0] <= eom_r ? shamh_pkg::PAD_MARK : 8'd0;
            endcase
          end
          // the marker goes out once; eom_r then means no marker owed
          if (eom_r && !(fin_r)) eom_r <= 1'b0;
          pad_r <= pad_r + 6'd1;
          if (pad_r == 6'd63) begin
            rnd_r <= '0;
            // second block needed: come back to a zero block with length
            if (!two_r && total_r[5:0] > 6'd55) two_r <= 1'b1;
          end
        end
        shamh_pkg::ST_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              total_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= shamh_pkg::init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  `include "sha256_message_hasher_core_assert.svh"

  `SHA_ASSERT_IMP(a_busy_no_ready, clk, rst_n,
    state_r != shamh_pkg::ST_IDLE, !in_tready)
  `SHA_ASSERT_IMP(a_out_only_in_out, clk, rst_n, out_tvalid,
    state_r == shamh_pkg::ST_OUT)
  `SHA_ASSERT_NXT(a_full_starts_round, clk, rst_n, blk_full,
    state_r == shamh_pkg::ST_ROUND)
  `SHA_ASSERT_IMP(a_fold_after_last, clk, rst_n, fold_r, rnd_r == 6'd0)

endmodule
`default_nettype wire
